// ===== rtl/binomial_smooth_2d_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for binomial_smooth_2d
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BINOMIAL_SMOOTH_2D_ASSERT_SVH
`define BINOMIAL_SMOOTH_2D_ASSERT_SVH

// same-cycle implication
`define BSM2D_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSM2D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bsm2d_pkg.sv =====
// ---------------------------------------------------------------------------
// bsm2d_pkg
// Shared constants and types of the separable 3x3 binomial smoothing block.
// ---------------------------------------------------------------------------
package bsm2d_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int SAMPLE_BITS   = 16;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS    = 11;
    localparam int HEIGHT_BITS   = 16;
    localparam int ROW_BITS      = SAMPLE_BITS + 2;
    localparam int OUT_BITS      = SAMPLE_BITS + 4;
    localparam int IN_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    // configuration port
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(1024);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(1024);

    // queue between front and back
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = QPTR_BITS + 1;
    localparam int FILL_BITS   = QCNT_BITS + 1;
    localparam int MAX_PUSH    = 2;
    localparam int PUSH_BITS   = 2;

    typedef enum logic
    {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic
    {
        REQ_SAMPLE = 1'b0,
        REQ_DRAIN  = 1'b1
    } req_type_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // one column of the 3x3 window: row above, middle row, row below
    typedef struct packed
    {
        sample_t top;
        sample_t mid;
        sample_t bot;
    } column_t;

    // one queued result: left, middle and right columns
    typedef struct packed
    {
        column_t lf;
        column_t md;
        column_t rt;
        logic    last;
    } qentry_t;

    // effective frame geometry and restart strobe
    typedef struct packed
    {
        logic [WIDTH_BITS-1:0]  width;
        logic [HEIGHT_BITS-1:0] height;
        logic                   width_lt3;
        logic                   height_lt3;
        logic                   height_ge2;
        logic                   restart;
    } cfg_t;

endpackage

// ===== rtl/bsm2d_cfg.sv =====
// ---------------------------------------------------------------------------
// bsm2d_cfg
// APB register file for frame width and height; derives effective geometry.
// ---------------------------------------------------------------------------
module bsm2d_cfg
    import bsm2d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic                   wr_en;
    reg_idx_t               idx;
    logic [WIDTH_BITS-1:0]  width_eff;
    logic [HEIGHT_BITS-1:0] height_eff;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = reg_idx_t'(paddr[2]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_WIDTH:  width_reg  <= pwdata[WIDTH_BITS-1:0];
                REG_HEIGHT: height_reg <= pwdata[HEIGHT_BITS-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_WIDTH:  prdata = PDATA_BITS'(width_reg);
            REG_HEIGHT: prdata = PDATA_BITS'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // clamp to the supported range
    always_comb
    begin
        priority if (width_reg == '0)
            width_eff = WIDTH_BITS'(1);
        else if (width_reg > WIDTH_BITS'(MAX_WIDTH))
            width_eff = WIDTH_BITS'(MAX_WIDTH);
        else
            width_eff = width_reg;
        height_eff = (height_reg == '0) ? HEIGHT_BITS'(1) : height_reg;
    end

    assign cfg.width      = width_eff;
    assign cfg.height     = height_eff;
    assign cfg.width_lt3  = width_eff < WIDTH_BITS'(3);
    assign cfg.height_lt3 = height_eff < HEIGHT_BITS'(3);
    assign cfg.height_ge2 = height_eff >= HEIGHT_BITS'(2);
    // any register write abandons the frame in progress
    assign cfg.restart    = wr_en;

endmodule

// ===== rtl/bsm2d_front.sv =====
// ---------------------------------------------------------------------------
// bsm2d_front
// Accepts words, tracks frame position, owns the two line buffers and the
// column window, and queues one entry per result it releases.
// ---------------------------------------------------------------------------
module bsm2d_front
    import bsm2d_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_type,
    input  sample_t              in_sample,
    input  logic [QCNT_BITS-1:0] q_count,
    output logic [PUSH_BITS-1:0] push_n,
    output qentry_t              push0,
    output qentry_t              push1
);

    typedef struct packed
    {
        logic drain;
        logic row_ge1;
        logic row_ge2;
        logic pos_ge1;
        logic pos_ge2;
        logic pos_last;
        logic bank;
    } s1_ctl_t;

    // position counters
    logic [COL_BITS-1:0]    col_reg;
    logic [COL_BITS-1:0]    drain_reg;
    logic [HEIGHT_BITS-1:0] row_reg;
    logic                   bank_reg;

    // line buffers, banks swap roles at each row end
    sample_t bank0_mem [MAX_WIDTH];
    sample_t bank1_mem [MAX_WIDTH];
    sample_t b0_rda_reg;
    sample_t b0_rdb_reg;
    sample_t b1_rda_reg;
    sample_t b1_rdb_reg;

    // stage 1
    logic    s1_valid_reg;
    s1_ctl_t s1_reg;
    s1_ctl_t s1_next;
    sample_t s1_x_reg;
    column_t p1_reg;
    column_t p2_reg;

    logic                  accept;
    logic                  row_full;
    logic                  do_sample;
    logic                  do_drain;
    logic                  rd_en;
    logic [WIDTH_BITS-1:0] col_inc;
    logic [WIDTH_BITS-1:0] drain_inc;
    logic                  col_last;
    logic                  drain_last;
    logic [COL_BITS-1:0]   rd_addr_a;
    logic [COL_BITS-1:0]   rd_addr_b;
    sample_t               older_a;
    sample_t               newer_a;
    sample_t               older_b;
    sample_t               newer_b;
    column_t               cur;
    column_t               col_k;
    column_t               col_k1;
    qentry_t               ent_mid;
    qentry_t               ent_edge;
    qentry_t               ent_drain;
    logic                  has_mid;
    logic                  has_edge;

    // room for what stage 1 pushes now plus the worst case of a new word
    assign in_ready = (FILL_BITS'(q_count) + FILL_BITS'(push_n) + FILL_BITS'(MAX_PUSH))
                      <= FILL_BITS'(QUEUE_DEPTH);

    // classify the accepted word
    assign accept     = in_valid & in_ready;
    assign row_full   = row_reg >= cfg.height;
    assign do_sample  = accept & (req_type_t'(in_type) == REQ_SAMPLE) & ~row_full;
    assign do_drain   = accept & (req_type_t'(in_type) == REQ_DRAIN) & row_full;
    assign rd_en      = do_sample | do_drain;

    assign col_inc    = WIDTH_BITS'(col_reg) + WIDTH_BITS'(1);
    assign drain_inc  = WIDTH_BITS'(drain_reg) + WIDTH_BITS'(1);
    assign col_last   = col_inc == cfg.width;
    assign drain_last = drain_inc >= cfg.width;
    assign rd_addr_a  = do_drain ? drain_reg : col_reg;
    assign rd_addr_b  = drain_last ? drain_reg : COL_BITS'(drain_inc);

    // frame position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            drain_reg <= '0;
            row_reg   <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            priority if (cfg.restart)
            begin
                col_reg   <= '0;
                drain_reg <= '0;
                row_reg   <= '0;
            end
            else if (do_sample)
            begin
                if (col_last)
                begin
                    col_reg  <= '0;
                    row_reg  <= row_reg + HEIGHT_BITS'(1);
                    bank_reg <= ~bank_reg;
                end
                else
                begin
                    col_reg <= COL_BITS'(col_inc);
                end
            end
            else if (do_drain)
            begin
                if (drain_last)
                begin
                    drain_reg <= '0;
                    row_reg   <= '0;
                    col_reg   <= '0;
                end
                else
                begin
                    drain_reg <= COL_BITS'(drain_inc);
                end
            end
        end
    end

    // bank 0: write the new sample, read old data at both ports
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            b0_rda_reg <= bank0_mem[rd_addr_a];
            b0_rdb_reg <= bank0_mem[rd_addr_b];
        end
        if (do_sample && !bank_reg)
            bank0_mem[col_reg] <= in_sample;
    end

    // bank 1
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            b1_rda_reg <= bank1_mem[rd_addr_a];
            b1_rdb_reg <= bank1_mem[rd_addr_b];
        end
        if (do_sample && bank_reg)
            bank1_mem[col_reg] <= in_sample;
    end

    // stage 1 control
    always_comb
    begin
        s1_next.drain    = do_drain;
        s1_next.row_ge1  = row_reg != '0;
        s1_next.row_ge2  = row_reg >= HEIGHT_BITS'(2);
        s1_next.pos_ge1  = do_drain ? (drain_reg != '0) : (col_reg != '0);
        s1_next.pos_ge2  = col_reg >= COL_BITS'(2);
        s1_next.pos_last = do_drain ? drain_last : col_last;
        s1_next.bank     = bank_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= rd_en;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_reg   <= s1_next;
            s1_x_reg <= in_sample;
        end
    end

    // older bank is the one the current row writes
    assign older_a = s1_reg.bank ? b1_rda_reg : b0_rda_reg;
    assign newer_a = s1_reg.bank ? b0_rda_reg : b1_rda_reg;
    assign older_b = s1_reg.bank ? b1_rdb_reg : b0_rdb_reg;
    assign newer_b = s1_reg.bank ? b0_rdb_reg : b1_rdb_reg;

    // columns: incoming sample column, drain columns k and k+1
    always_comb
    begin
        cur.top    = s1_reg.row_ge2 ? older_a : newer_a;
        cur.mid    = newer_a;
        cur.bot    = s1_x_reg;
        col_k.top  = cfg.height_ge2 ? older_a : newer_a;
        col_k.mid  = newer_a;
        col_k.bot  = newer_a;
        col_k1.top = cfg.height_ge2 ? older_b : newer_b;
        col_k1.mid = newer_b;
        col_k1.bot = newer_b;
    end

    // result entries
    always_comb
    begin
        ent_mid.lf    = s1_reg.pos_ge2 ? p2_reg : p1_reg;
        ent_mid.md    = p1_reg;
        ent_mid.rt    = cur;
        ent_mid.last  = 1'b0;
        ent_edge.lf   = s1_reg.pos_ge1 ? p1_reg : cur;
        ent_edge.md   = cur;
        ent_edge.rt   = cur;
        ent_edge.last = 1'b0;
        ent_drain.lf   = s1_reg.pos_ge1 ? p1_reg : col_k;
        ent_drain.md   = col_k;
        ent_drain.rt   = col_k1;
        ent_drain.last = s1_reg.pos_last;
    end

    assign has_mid  = s1_reg.row_ge1 & s1_reg.pos_ge1;
    assign has_edge = s1_reg.row_ge1 & s1_reg.pos_last;

    // queue pushes, the interior result goes first
    always_comb
    begin
        push0  = ent_drain;
        push1  = ent_edge;
        push_n = '0;
        if (s1_valid_reg)
        begin
            priority if (s1_reg.drain)
            begin
                push_n = PUSH_BITS'(1);
            end
            else if (has_mid)
            begin
                push0  = ent_mid;
                push_n = has_edge ? PUSH_BITS'(2) : PUSH_BITS'(1);
            end
            else if (has_edge)
            begin
                push0  = ent_edge;
                push_n = PUSH_BITS'(1);
            end
        end
    end

    // column window
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            if (s1_reg.drain)
            begin
                p1_reg <= col_k;
            end
            else
            begin
                p2_reg <= p1_reg;
                p1_reg <= cur;
            end
        end
    end

endmodule

// ===== rtl/bsm2d_queue.sv =====
// ---------------------------------------------------------------------------
// bsm2d_queue
// Small FIFO of pending results; takes up to two entries and gives one a cycle when popped.
// ---------------------------------------------------------------------------
module bsm2d_queue
    import bsm2d_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [PUSH_BITS-1:0] push_n,
    input  qentry_t              push0,
    input  qentry_t              push1,
    input  logic                 pop,
    output qentry_t              head,
    output logic [QCNT_BITS-1:0] count
);

    qentry_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QPTR_BITS-1:0] wr_ptr_p1;

    assign wr_ptr_p1 = wr_ptr_reg + QPTR_BITS'(1);
    assign head      = entries_reg[rd_ptr_reg];
    assign count     = count_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (push_n != '0)
            entries_reg[wr_ptr_reg] <= push0;
        if (push_n == PUSH_BITS'(2))
            entries_reg[wr_ptr_p1] <= push1;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(push_n);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            count_reg <= count_reg + QCNT_BITS'(push_n) - QCNT_BITS'(pop);
        end
    end

endmodule

// ===== rtl/bsm2d_back.sv =====
// ---------------------------------------------------------------------------
// bsm2d_back
// Row pass, then column pass, then the output register of the result stream.
// ---------------------------------------------------------------------------
module bsm2d_back
    import bsm2d_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  qentry_t                    in_entry,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [OUT_BITS-1:0] out_value,
    output logic                       out_last
);

    // [1,2,1] along a row, or x4 when the row is too short
    function automatic logic signed [ROW_BITS-1:0] row_sum(
        sample_t l, sample_t m, sample_t r, logic short_dim);
        logic signed [ROW_BITS-1:0] le;
        logic signed [ROW_BITS-1:0] me;
        logic signed [ROW_BITS-1:0] re;
        le = ROW_BITS'(l);
        me = ROW_BITS'(m);
        re = ROW_BITS'(r);
        return short_dim ? (me <<< 2) : (le + (me <<< 1) + re);
    endfunction

    // [1,2,1] along a column, or x4 when the frame is too short
    function automatic logic signed [OUT_BITS-1:0] col_sum(
        logic signed [ROW_BITS-1:0] t, logic signed [ROW_BITS-1:0] m,
        logic signed [ROW_BITS-1:0] b, logic short_dim);
        logic signed [OUT_BITS-1:0] te;
        logic signed [OUT_BITS-1:0] me;
        logic signed [OUT_BITS-1:0] be;
        te = OUT_BITS'(t);
        me = OUT_BITS'(m);
        be = OUT_BITS'(b);
        return short_dim ? (me <<< 2) : (te + (me <<< 1) + be);
    endfunction

    logic                       b1_valid_reg;
    logic signed [ROW_BITS-1:0] b1_top_reg;
    logic signed [ROW_BITS-1:0] b1_mid_reg;
    logic signed [ROW_BITS-1:0] b1_bot_reg;
    logic                       b1_last_reg;
    logic                       out_valid_reg;
    logic signed [OUT_BITS-1:0] out_value_reg;
    logic                       out_last_reg;
    logic                       out_free;

    assign out_free  = ~out_valid_reg | out_ready;
    assign in_ready  = ~b1_valid_reg | out_free;
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                b1_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= b1_valid_reg;
        end
    end

    // row pass on the three window rows
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            b1_top_reg  <= row_sum(in_entry.lf.top, in_entry.md.top, in_entry.rt.top,
                                   cfg.width_lt3);
            b1_mid_reg  <= row_sum(in_entry.lf.mid, in_entry.md.mid, in_entry.rt.mid,
                                   cfg.width_lt3);
            b1_bot_reg  <= row_sum(in_entry.lf.bot, in_entry.md.bot, in_entry.rt.bot,
                                   cfg.width_lt3);
            b1_last_reg <= in_entry.last;
        end
    end

    // column pass into the output register
    always_ff @(posedge clk)
    begin
        if (out_free && b1_valid_reg)
        begin
            out_value_reg <= col_sum(b1_top_reg, b1_mid_reg, b1_bot_reg, cfg.height_lt3);
            out_last_reg  <= b1_last_reg;
        end
    end

endmodule

// ===== rtl/binomial_smooth_2d.sv =====
// Path: a result word reaches m_axis after the input word that releases it passes the
//   line buffer read, the queue write, the row pass and the column pass; the second
//   result of a row end follows the first; results trail the input by one row, and the
//   final row is released by drain words, one per word.
// Throughput: 1 input word and 1 result per cycle, unless queue or m_axis stalls.
// Reset: rst_n is asynchronous, active low; it clears counters, queue and valid flags,
//   and sets frame_width and frame_height to 1024. Line buffers are not cleared.
// ---------------------------------------------------------------------------
// binomial_smooth_2d
// Separable [1,2,1] x [1,2,1] smoothing of a raster frame (gain 16, not normalized), edge replicated.
// ---------------------------------------------------------------------------
`include "binomial_smooth_2d_assert.svh"

module binomial_smooth_2d
    import bsm2d_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,   // [15:0] sample_value
    input  logic [0:0]                s_axis_tuser,   // [0] req_type
    // result stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,   // [19:0] smoothed_value, rest zero
    output logic                      m_axis_tlast,   // frame_last
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_BITS-1:0]     paddr,
    input  logic [PDATA_BITS-1:0]     pwdata,
    output logic [PDATA_BITS-1:0]     prdata,
    output logic                      pready
);

    cfg_t                       cfg;
    logic [QCNT_BITS-1:0]       q_count;
    logic [PUSH_BITS-1:0]       q_push_n;
    qentry_t                    q_push0;
    qentry_t                    q_push1;
    qentry_t                    q_head;
    logic                       back_in_valid;
    logic                       back_in_ready;
    logic                       q_pop;
    logic signed [OUT_BITS-1:0] back_value;

    bsm2d_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bsm2d_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_type   (s_axis_tuser[0]),
        .in_sample (sample_t'(s_axis_tdata[SAMPLE_BITS-1:0])),
        .q_count   (q_count),
        .push_n    (q_push_n),
        .push0     (q_push0),
        .push1     (q_push1)
    );

    bsm2d_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_n (q_push_n),
        .push0  (q_push0),
        .push1  (q_push1),
        .pop    (q_pop),
        .head   (q_head),
        .count  (q_count)
    );

    assign back_in_valid = q_count != '0;
    assign q_pop         = back_in_valid & back_in_ready;

    bsm2d_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (back_in_valid),
        .in_ready  (back_in_ready),
        .in_entry  (q_head),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (back_value),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TDATA_BITS'($unsigned(back_value));

    // queue fill never passes its depth
    `BSM2D_ASSERT_IMPLY(a_q_bound, 1'b1, q_count <= QCNT_BITS'(QUEUE_DEPTH), "queue overflow")
    // a full queue holds off new input words
    `BSM2D_ASSERT_IMPLY(a_full_stall, q_count == QCNT_BITS'(QUEUE_DEPTH), !s_axis_tready,
                        "input taken with full queue")
    // a waiting entry is not lost while the back end stalls
    `BSM2D_ASSERT_NEXT(a_q_hold, back_in_valid && !back_in_ready, back_in_valid,
                       "queued result dropped")

endmodule
